>>> hw/rtl/tht_pkg.sv
// Package: types, constants and the thermistor curve for the heater thermostat.
package tht_pkg;
    localparam int TABLE_ENTRIES = 140;
    localparam int unsigned HOT_LIMIT = 50;
    localparam logic [1:0] MODE_AUTO = 2'd2;
    localparam logic [1:0] REG_MODE = 2'd0;
    localparam logic [1:0] REG_MIN = 2'd1;
    localparam logic [1:0] REG_MAX = 2'd2;
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_MANUAL = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE, ST_DIV, ST_SCAN, ST_IDIV, ST_RULE, ST_OUT
    } t_state;

    // curve centres in thousandths of a kohm, index 0 is -40 degrees
    function automatic logic [17:0] curve_milli(input logic [7:0] i);
        logic [17:0] m;
        case (i)
            0: m = 197390; 1: m = 186540; 2: m = 176350; 3: m = 166800;
            4: m = 157820; 5: m = 149390; 6: m = 141510; 7: m = 134090;
            8: m = 127110; 9: m = 120530; 10: m = 114340; 11: m = 108530;
            12: m = 103040; 13: m = 97870; 14: m = 92989; 15: m = 88381;
            16: m = 84036; 17: m = 79931; 18: m = 76052; 19: m = 72384;
            20: m = 68915; 21: m = 65634; 22: m = 62529; 23: m = 59589;
            24: m = 56804; 25: m = 54166; 26: m = 51665; 27: m = 49294;
            28: m = 47046; 29: m = 44913; 30: m = 42889; 31: m = 40967;
            32: m = 39142; 33: m = 37408; 34: m = 35761; 35: m = 34196;
            36: m = 32707; 37: m = 31291; 38: m = 29945; 39: m = 28664;
            40: m = 27445; 41: m = 26283; 42: m = 25177; 43: m = 24124;
            44: m = 23121; 45: m = 22165; 46: m = 21253; 47: m = 20384;
            48: m = 19555; 49: m = 18764; 50: m = 18010; 51: m = 17290;
            52: m = 16602; 53: m = 15946; 54: m = 15319; 55: m = 14720;
            56: m = 14148; 57: m = 13601; 58: m = 13078; 59: m = 12578;
            60: m = 12099; 61: m = 11642; 62: m = 11204; 63: m = 10785;
            64: m = 10384; 65: m = 10000; 66: m = 9632; 67: m = 9280;
            68: m = 8943; 69: m = 8619; 70: m = 8309; 71: m = 8012;
            72: m = 7727; 73: m = 7453; 74: m = 7191; 75: m = 6939;
            76: m = 6698; 77: m = 6466; 78: m = 6243; 79: m = 6029;
            80: m = 5824; 81: m = 5627; 82: m = 5437; 83: m = 5080;
            84: m = 4911; 85: m = 4749; 86: m = 4593; 87: m = 4443;
            88: m = 4299; 89: m = 4160; 90: m = 4027; 91: m = 3898;
            92: m = 3774; 93: m = 3654; 94: m = 3539; 95: m = 3429;
            96: m = 3322; 97: m = 3219; 98: m = 3119; 99: m = 3024;
            100: m = 2931; 101: m = 2842; 102: m = 2756; 103: m = 2673;
            104: m = 2593; 105: m = 2516; 106: m = 2441; 107: m = 2369;
            108: m = 2300; 109: m = 2233; 110: m = 2168; 111: m = 2105;
            112: m = 2044; 113: m = 1986; 114: m = 1929; 115: m = 1874;
            116: m = 1821; 117: m = 1770; 118: m = 1720; 119: m = 1673;
            120: m = 1626; 121: m = 1581; 122: m = 1538; 123: m = 1496;
            124: m = 1455; 125: m = 1416; 126: m = 1377; 127: m = 1340;
            128: m = 1304; 129: m = 1270; 130: m = 1236; 131: m = 1204;
            132: m = 1172; 133: m = 1141; 134: m = 1112; 135: m = 1083;
            136: m = 1055; 137: m = 1028; 138: m = 1002; 139: m = 976;
            default: m = 976;
        endcase
        return m;
    endfunction

    function automatic logic signed [7:0] curve_deg(input logic [7:0] i);
        logic signed [8:0] d;
        if (i > 8'd82) d = $signed({1'b0, i}) - 9'sd39;
        else d = $signed({1'b0, i}) - 9'sd40;
        return d[7:0];
    endfunction

    // centre in Q16, rounded half up; divide by a constant
    function automatic logic [23:0] centre_q16(input logic [7:0] i);
        logic [34:0] p;
        p = {1'b0, curve_milli(i), 16'd0} + 35'd500;
        return 24'(p / 35'd1000);
    endfunction
endpackage

>>> hw/rtl/thermistor_heater_thermostat.sv
// Top level: thermistor heater thermostat with curve scan and bang-bang control.
// A sample word is accepted while idle and then passes through these steps, and a
// manual set, or a sample outside auto mode, goes straight to the last two: a
// bit-serial divider forms the Q16 resistance, the curve is scanned one centre per
// cycle until an interval is found (or the scan stops below or above the table), a
// second bit-serial divider does the interpolation, then the rule state reads and
// writes back the heater flag in a one-word synchronous flag memory and the output
// state presents the result; a stalled result holds the block in the output state.
// One word is in flight at a time.
module thermistor_heater_thermostat
    import tht_pkg::*;
#(
    parameter int CHANNELS = 2,
    parameter int ADC_BITS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: channel[0], adc_code[ADC_BITS:1], enable[ADC_BITS+1], zero fill
    input  logic [((ADC_BITS+9)/8)*8-1:0] s_axis_tdata,
    // tuser: operation
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: out_channel[0], temperature[8:1], temp_valid[9], heater_on[10],
    // pin_written[11], over_limit[12], zero fill
    output logic [15:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_wdata
);
    localparam int QW = ADC_BITS + 16;
    localparam int FW = (CHANNELS > 1) ? CHANNELS : 2;
    localparam int NW = 32;

    t_state r_state, n_state;
    logic [1:0] r_mode;
    logic signed [7:0] r_min, r_max;
    logic r_op, r_en, r_ch;
    logic [ADC_BITS-1:0] r_code;
    logic [QW-1:0] r_q, n_q;
    logic [QW:0] r_rem, n_rem;
    logic [5:0] r_cnt, n_cnt;
    logic [7:0] r_idx, n_idx;
    logic [NW-1:0] r_num, n_num;
    logic [NW-1:0] r_den;
    logic [NW:0] r_irem, n_irem;
    logic signed [7:0] r_deg, n_deg;
    logic signed [7:0] r_t1;
    logic w_vld, w_wr, w_hot, w_on;
    logic [FW-1:0] r_mem [0:0];
    logic [FW-1:0] r_rd;
    logic r_mem_clr;
    logic [QW-1:0] w_r;
    logic [23:0] w_centre [0:255];
    logic [23:0] w_c1, w_c2;
    logic [23:0] w_span;
    logic [7:0] w_dt;
    logic [QW+1:0] w_rem_sh;
    logic [NW:0] w_irem_sh;
    logic [FW-1:0] w_flags, w_new;
    logic signed [8:0] w_diff;
    logic [7:0] w_mag;
    logic [7:0] w_third;
    logic signed [9:0] w_mid;
    logic w_cur, w_bit;
    logic [15:0] w_out;

    for (genvar g = 0; g < 256; g++) begin : g_centre
        assign w_centre[g] = centre_q16(8'(g));
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_r = r_q;
    assign w_c1 = w_centre[r_idx];
    assign w_c2 = w_centre[r_idx + 8'd1];
    assign w_span = w_c1 - 24'(w_r);
    assign w_dt = 8'(curve_deg(r_idx + 8'd1) - curve_deg(r_idx));
    assign w_rem_sh = {r_rem, r_q[QW-1]};
    assign w_irem_sh = {r_irem[NW-1:0], r_num[NW-1]};
    assign w_flags = r_mem_clr ? '0 : r_rd;
    assign w_cur = w_flags[r_ch];
    assign w_diff = 9'(r_max) - 9'(r_min);
    assign w_mag = w_diff[8] ? 8'(-w_diff) : 8'(w_diff);
    assign w_third = 8'((16'(w_mag) * 16'd171) >> 9);
    assign w_mid = 10'(r_min) + (w_diff[8] ? -(10'(w_third)) : 10'(w_third));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_mode <= MODE_AUTO;
            r_min <= '0;
            r_max <= '0;
            r_mem_clr <= 1'b1;
            m_axis_tvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_MODE: begin
                        r_mode <= i_cfg_wdata[1:0];
                        r_mem_clr <= 1'b1;
                    end
                    REG_MIN: r_min <= i_cfg_wdata;
                    REG_MAX: r_max <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (r_state == ST_RULE) r_mem_clr <= 1'b0;
            if (r_state == ST_RULE) m_axis_tvalid <= 1'b1;
            else if (m_axis_tready) m_axis_tvalid <= 1'b0;
        end
    end

    // flag memory: one word, registered read
    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[0];
        if (r_state == ST_RULE) r_mem[0] <= w_new;
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
        r_rem <= n_rem;
        r_cnt <= n_cnt;
        r_idx <= n_idx;
        r_num <= n_num;
        r_irem <= n_irem;
        r_deg <= n_deg;
        if (s_axis_tvalid && s_axis_tready) begin
            r_op <= s_axis_tuser;
            r_ch <= s_axis_tdata[0];
            r_code <= s_axis_tdata[ADC_BITS:1];
            r_en <= s_axis_tdata[ADC_BITS+1];
        end
        if (r_state == ST_SCAN) begin
            r_den <= NW'(w_c1 - w_c2);
            r_t1 <= curve_deg(r_idx);
        end
        if (r_state == ST_RULE) begin
            m_axis_tdata <= w_out;
        end
    end

    always_comb begin
        n_state = r_state;
        n_q = r_q;
        n_rem = r_rem;
        n_cnt = r_cnt;
        n_idx = r_idx;
        n_num = r_num;
        n_irem = r_irem;
        n_deg = r_deg;
        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_q = {s_axis_tdata[ADC_BITS:1], 16'd0};
                    n_rem = '0;
                    n_cnt = '0;
                    n_idx = '0;
                    n_deg = '0;
                    if (s_axis_tuser == OP_MANUAL || 32'(s_axis_tdata[0]) >= CHANNELS
                        || r_mode != MODE_AUTO)
                        n_state = ST_RULE;
                    else
                        n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                n_rem = w_rem_sh[QW:0];
                n_q = {r_q[QW-2:0], 1'b0};
                if (w_rem_sh >= {2'b0, (QW'(1) << ADC_BITS) - QW'(r_code)}) begin
                    n_rem = (QW+1)'(w_rem_sh - {2'b0, (QW'(1) << ADC_BITS) - QW'(r_code)});
                    n_q[0] = 1'b1;
                end
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'(QW-1)) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (QW'(w_c1) < w_r && r_idx == 8'd0) begin
                    n_deg = curve_deg(8'd0);
                    n_state = ST_RULE;
                end else if (r_idx == 8'(TABLE_ENTRIES - 1)) begin
                    n_deg = curve_deg(8'(TABLE_ENTRIES - 1));
                    n_state = ST_RULE;
                end else if (w_r >= QW'(w_c2)) begin
                    n_num = NW'(32'(w_span) * 32'(w_dt));
                    n_irem = '0;
                    n_cnt = '0;
                    n_state = (w_c1 == w_c2) ? ST_RULE : ST_IDIV;
                    n_deg = curve_deg(r_idx);
                end else begin
                    n_idx = r_idx + 8'd1;
                end
            end
            ST_IDIV: begin
                n_irem = w_irem_sh;
                n_num = {r_num[NW-2:0], 1'b0};
                if (w_irem_sh >= {1'b0, r_den}) begin
                    n_irem = w_irem_sh - {1'b0, r_den};
                    n_num[0] = 1'b1;
                end
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'(NW-1)) begin
                    n_deg = r_t1 + 8'(n_num);
                    // truncate toward zero below zero degrees
                    if (n_deg[7] && n_irem != '0) n_deg = n_deg + 8'sd1;
                    n_state = ST_RULE;
                end
            end
            ST_RULE: n_state = ST_OUT;
            ST_OUT: if (!m_axis_tvalid || m_axis_tready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_new = w_flags;
        w_bit = 1'b0;
        w_vld = 1'b0;
        w_wr = 1'b0;
        w_hot = 1'b0;
        w_on = 1'b0;
        if (32'(r_ch) < CHANNELS) begin
            if (r_op == OP_MANUAL) begin
                w_new[r_ch] = r_en;
                w_wr = 1'b1;
            end else if (r_mode == MODE_AUTO) begin
                w_vld = 1'b1;
                if (r_deg > 8'sd50) begin
                    w_new[r_ch] = 1'b0;
                    w_wr = 1'b1;
                    w_hot = 1'b1;
                end else if (10'(r_deg) == w_mid) begin
                    if (w_cur) begin w_new[r_ch] = 1'b0; w_wr = 1'b1; end
                end else if (r_deg < r_min) begin
                    if (!w_cur) begin w_new[r_ch] = 1'b1; w_wr = 1'b1; end
                end else if (r_deg > r_max) begin
                    if (w_cur) begin w_new[r_ch] = 1'b0; w_wr = 1'b1; end
                end
            end
            w_bit = w_new[r_ch];
            w_on = w_bit;
        end
        w_out = {3'b0, w_hot, w_wr, w_on, w_vld, (w_vld ? r_deg : 8'sd0), r_ch};
    end
endmodule

>>> hw/rtl/tht_checker.sv
// Checker: port-level properties of the heater thermostat, and its bind.
module tht_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word dropped while stalled");
    a_hot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[12] |-> m_axis_tdata[9] && m_axis_tdata[11]
        && !m_axis_tdata[10]) else $error("over limit without cut-off");
    a_temp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[9] |-> m_axis_tdata[8:1] == 8'd0 && !m_axis_tdata[12])
        else $error("temperature without evaluation");
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second word taken while busy");
endmodule

bind thermistor_heater_thermostat tht_checker u_tht_checker (.*);
